// File: sv/source_tokenizer_core_assert.svh
// ----------------------------------------------------------------------------
// source_tokenizer_core_assert.svh
// assertion macros used by the tokenizer checker
// ----------------------------------------------------------------------------
`ifndef SOURCE_TOKENIZER_CORE_ASSERT_SVH
`define SOURCE_TOKENIZER_CORE_ASSERT_SVH

// same-cycle implication, quiet during reset
`define STT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tokenizer check failed");

// next-cycle implication, quiet during reset
`define STT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tokenizer check failed");

`endif

// File: sv/sttok_pkg.sv
// ----------------------------------------------------------------------------
// sttok_pkg
// types and constants of the source tokenizer
// ----------------------------------------------------------------------------
package sttok_pkg;

  localparam int unsigned POSITION_BITS   = 16;
  localparam int unsigned IDENT_MAX_CHARS = 8;
  localparam int unsigned TAB_STOP        = 8;
  localparam int unsigned PHASE_BITS      = 4;
  localparam int unsigned QUEUE_DEPTH     = 4;
  localparam int unsigned POS_MAX_INT     = (1 << POSITION_BITS) - 1;
  localparam logic [POSITION_BITS-1:0] POS_MAX = POSITION_BITS'(POS_MAX_INT);
  localparam logic [PHASE_BITS-1:0] TAB_PHASE_SAT =
    PHASE_BITS'((POS_MAX_INT - 1) % TAB_STOP);

  localparam logic [7:0] CH_EQUALS     = 8'h3D;
  localparam logic [7:0] CH_PLUS       = 8'h2B;
  localparam logic [7:0] CH_MINUS      = 8'h2D;
  localparam logic [7:0] CH_STAR       = 8'h2A;
  localparam logic [7:0] CH_SLASH      = 8'h2F;
  localparam logic [7:0] CH_SEMI       = 8'h3B;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_NEWLINE    = 8'h0A;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [63:0] KW_INT_CHARS = 64'h0000_0000_0074_6E69;

  typedef enum logic [3:0] {
    TK_IDENT   = 4'd0,
    TK_KW_INT  = 4'd1,
    TK_NUMBER  = 4'd2,
    TK_EQUALS  = 4'd3,
    TK_PLUS    = 4'd4,
    TK_MINUS   = 4'd5,
    TK_STAR    = 4'd6,
    TK_SLASH   = 4'd7,
    TK_SEMI    = 4'd8,
    TK_END     = 4'd9,
    TK_UNKNOWN = 4'd10
  } tok_kind_e;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'b001,
    MODE_IDENT  = 3'b010,
    MODE_NUMBER = 3'b100
  } scan_mode_e;

  typedef struct packed {
    logic                     vld;
    tok_kind_e                kind;
    logic [POSITION_BITS-1:0] line;
    logic [POSITION_BITS-1:0] column;
    logic [26:0]              num;
    logic [63:0]              chars;
    logic [3:0]               len;
    logic                     err;
    logic                     sticky;
  } token_t;

  // one source byte yields at most a flushed token and then one more
  typedef struct packed {
    token_t first;
    token_t second;
  } entry_t;

endpackage

// File: sv/sttok_front.sv
// ----------------------------------------------------------------------------
// sttok_front
// classifies source bytes, tracks position and builds token entries
// ----------------------------------------------------------------------------
module sttok_front import sttok_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] byte_i,
  input  logic       eoi_i,
  output logic       push_o,
  output entry_t     entry_o
);

  scan_mode_e               mode_q, mode_d;
  logic [POSITION_BITS-1:0] line_q, line_d, col_q, col_d;
  logic [POSITION_BITS-1:0] sline_q, sline_d, scol_q, scol_d;
  logic [PHASE_BITS-1:0]    phase_q, phase_d;
  logic [63:0]              buf_q, buf_d;
  logic [3:0]               kept_q, kept_d;
  logic [26:0]              acc_q, acc_d;
  logic                     err_seen_q, err_seen_d;
  logic                     fin_q, fin_d;

  logic                     is_alpha, is_digit, is_space, is_end;
  logic [POSITION_BITS-1:0] col_inc;
  logic [PHASE_BITS-1:0]    phase_inc;
  logic [POSITION_BITS:0]   tab_sum;
  token_t                   pend, sym;
  tok_kind_e                sym_kind;

  always_comb begin
    is_alpha = (byte_i inside {[8'h61:8'h7A], [8'h41:8'h5A]}) || (byte_i == CH_UNDERSCORE);
    is_digit = byte_i inside {[8'h30:8'h39]};
    is_space = byte_i inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    is_end   = eoi_i || (byte_i == 8'h00);
    col_inc   = (col_q == POS_MAX) ? col_q : col_q + 1'b1;
    phase_inc = (col_q == POS_MAX) ? phase_q :
                (phase_q == PHASE_BITS'(TAB_STOP - 1)) ? '0 : phase_q + 1'b1;
    tab_sum = {1'b0, col_q} + (POSITION_BITS+1)'(TAB_STOP)
              - (POSITION_BITS+1)'(phase_q);

    pend        = '0;
    pend.vld    = (mode_q != MODE_IDLE);
    pend.line   = sline_q;
    pend.column = scol_q;
    pend.sticky = err_seen_q;
    if (mode_q == MODE_IDENT) begin
      pend.kind  = (kept_q == 4'd3 && buf_q == KW_INT_CHARS) ? TK_KW_INT : TK_IDENT;
      pend.chars = buf_q;
      pend.len   = kept_q;
    end else begin
      pend.kind = TK_NUMBER;
      pend.num  = acc_q;
    end

    case (byte_i)
      CH_EQUALS: sym_kind = TK_EQUALS;
      CH_PLUS:   sym_kind = TK_PLUS;
      CH_MINUS:  sym_kind = TK_MINUS;
      CH_STAR:   sym_kind = TK_STAR;
      CH_SLASH:  sym_kind = TK_SLASH;
      CH_SEMI:   sym_kind = TK_SEMI;
      default:   sym_kind = TK_UNKNOWN;
    endcase
    sym        = '0;
    sym.line   = line_q;
    sym.column = col_q;

    mode_d     = mode_q;
    line_d     = line_q;
    col_d      = col_q;
    sline_d    = sline_q;
    scol_d     = scol_q;
    phase_d    = phase_q;
    buf_d      = buf_q;
    kept_d     = kept_q;
    acc_d      = acc_q;
    err_seen_d = err_seen_q;
    fin_d      = fin_q;
    entry_o    = '0;

    if (accept_i && !fin_q) begin
      if (is_end) begin
        entry_o.first      = pend;
        sym.vld            = 1'b1;
        sym.kind           = TK_END;
        sym.sticky         = err_seen_q;
        entry_o.second     = sym;
        fin_d              = 1'b1;
        mode_d             = MODE_IDLE;
        buf_d              = '0;
        kept_d             = '0;
        acc_d              = '0;
      end else if (mode_q == MODE_IDENT && (is_alpha || is_digit)) begin
        if (kept_q < 4'(IDENT_MAX_CHARS)) begin
          buf_d[kept_q[2:0]*8 +: 8] = byte_i;
          kept_d = kept_q + 1'b1;
        end
        col_d   = col_inc;
        phase_d = phase_inc;
      end else if (mode_q == MODE_NUMBER && is_digit) begin
        if (kept_q < 4'(IDENT_MAX_CHARS)) begin
          acc_d  = (acc_q << 3) + (acc_q << 1) + 27'(byte_i[3:0]);
          kept_d = kept_q + 1'b1;
        end
        col_d   = col_inc;
        phase_d = phase_inc;
      end else begin
        entry_o.first = pend;
        mode_d = MODE_IDLE;
        buf_d  = '0;
        kept_d = '0;
        acc_d  = '0;
        if (is_alpha) begin
          mode_d  = MODE_IDENT;
          sline_d = line_q;
          scol_d  = col_q;
          buf_d   = {56'd0, byte_i};
          kept_d  = 4'd1;
          col_d   = col_inc;
          phase_d = phase_inc;
        end else if (is_digit) begin
          mode_d  = MODE_NUMBER;
          sline_d = line_q;
          scol_d  = col_q;
          acc_d   = 27'(byte_i[3:0]);
          kept_d  = 4'd1;
          col_d   = col_inc;
          phase_d = phase_inc;
        end else if (is_space) begin
          if (byte_i == CH_NEWLINE) begin
            col_d   = POSITION_BITS'(1);
            phase_d = '0;
            line_d  = (line_q == POS_MAX) ? line_q : line_q + 1'b1;
          end else if (byte_i == CH_TAB) begin
            if (tab_sum >= {1'b0, POS_MAX}) begin
              col_d   = POS_MAX;
              phase_d = TAB_PHASE_SAT;
            end else begin
              col_d   = tab_sum[POSITION_BITS-1:0];
              phase_d = '0;
            end
          end else begin
            col_d   = col_inc;
            phase_d = phase_inc;
          end
        end else begin
          sym.vld        = 1'b1;
          sym.kind       = sym_kind;
          sym.err        = (sym_kind == TK_UNKNOWN);
          sym.sticky     = err_seen_q || sym.err;
          err_seen_d     = sym.sticky;
          entry_o.second = sym;
          col_d          = col_inc;
          phase_d        = phase_inc;
        end
      end
    end
    push_o = entry_o.first.vld || entry_o.second.vld;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      line_q     <= POSITION_BITS'(1);
      col_q      <= POSITION_BITS'(1);
      sline_q    <= POSITION_BITS'(1);
      scol_q     <= POSITION_BITS'(1);
      phase_q    <= '0;
      buf_q      <= '0;
      kept_q     <= '0;
      acc_q      <= '0;
      err_seen_q <= 1'b0;
      fin_q      <= 1'b0;
    end else begin
      mode_q     <= mode_d;
      line_q     <= line_d;
      col_q      <= col_d;
      sline_q    <= sline_d;
      scol_q     <= scol_d;
      phase_q    <= phase_d;
      buf_q      <= buf_d;
      kept_q     <= kept_d;
      acc_q      <= acc_d;
      err_seen_q <= err_seen_d;
      fin_q      <= fin_d;
    end
  end

endmodule

// File: sv/sttok_queue.sv
// ----------------------------------------------------------------------------
// sttok_queue
// short entry queue between the scanner and the token emitter
// ----------------------------------------------------------------------------
module sttok_queue import sttok_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_data_i,
  input  logic   pop_i,
  output entry_t head_o,
  output logic   empty_o,
  output logic   full_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  entry_t            mem_q [DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntW'(DEPTH));
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      count_q <= count_q + CntW'(push_i) - CntW'(pop_i);
    end
  end

endmodule

// File: sv/sttok_back.sv
// ----------------------------------------------------------------------------
// sttok_back
// splits queue entries into single tokens and holds the output register
// ----------------------------------------------------------------------------
module sttok_back import sttok_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  entry_t head_i,
  input  logic   empty_i,
  output logic   pop_o,
  input  logic   out_ready_i,
  output logic   out_valid_o,
  output token_t out_tok_o,
  output logic   out_last_o
);

  logic   valid_q;
  logic   beat_q, beat_d;
  logic   load;
  logic   send_first;
  token_t tok_d;
  logic   last_d;

  assign load        = !valid_q || out_ready_i;
  assign send_first  = head_i.first.vld && !beat_q;
  assign out_valid_o = valid_q;

  always_comb begin
    pop_o  = 1'b0;
    beat_d = beat_q;
    tok_d  = send_first ? head_i.first : head_i.second;
    last_d = send_first ? !head_i.second.vld : 1'b1;
    if (load && !empty_i) begin
      if (send_first && head_i.second.vld) begin
        beat_d = 1'b1;
      end else begin
        beat_d = 1'b0;
        pop_o  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      beat_q  <= 1'b0;
    end else begin
      beat_q <= beat_d;
      if (load) begin
        valid_q <= !empty_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && !empty_i) begin
      out_tok_o  <= tok_d;
      out_last_o <= last_d;
    end
  end

endmodule

// File: sv/source_tokenizer_core.sv
// ----------------------------------------------------------------------------
// source_tokenizer_core
// streaming tokenizer: source bytes in, identifier, number and symbol tokens out
//
// channel  dir  fields (low bit first)
// s_axis   in   tdata: source_byte[7:0]; tlast: end_of_input
// m_axis   out  tdata: line, column, number_value, ident_chars, ident_length,
//               sticky_error; tuser: token_kind, token_error; tlast: last_of_run
//
// one source byte is taken each cycle while the four-entry queue has room
// a byte that yields two tokens is sent by the emitter as two separate output beats
// a token is written into the queue and then into the output register before m_axis presents it
// reset clears scanner state, queue pointers and output valid
// output stalls fill the queue and then drop s_axis_tready
// ----------------------------------------------------------------------------
module source_tokenizer_core import sttok_pkg::*; #(
  parameter int unsigned QUEUE_ENTRIES = QUEUE_DEPTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // source_byte
  input  logic         s_axis_tlast,   // end_of_input
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // token_line, token_column, number_value, ident_chars, ident_length, sticky_error
  output logic [127:0] m_axis_tdata,
  output logic [4:0]   m_axis_tuser,   // token_kind, token_error
  output logic         m_axis_tlast    // last_of_run
);

  logic   accept, push, pop, empty, full;
  entry_t entry, head;
  token_t tok;

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  sttok_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .byte_i  (s_axis_tdata),
    .eoi_i   (s_axis_tlast),
    .push_o  (push),
    .entry_o (entry)
  );

  sttok_queue #(
    .DEPTH(QUEUE_ENTRIES)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(entry),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (empty),
    .full_o     (full)
  );

  sttok_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .empty_i    (empty),
    .pop_o      (pop),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_tok_o  (tok),
    .out_last_o (m_axis_tlast)
  );

  assign m_axis_tdata = {tok.sticky, tok.len, tok.chars, tok.num, tok.column, tok.line};
  assign m_axis_tuser = {tok.err, tok.kind};

endmodule

// File: sv/sttok_checker.sv
// ----------------------------------------------------------------------------
// sttok_checker
// port-level checks on the tokenizer output stream
// ----------------------------------------------------------------------------
`include "source_tokenizer_core_assert.svh"

module sttok_checker import sttok_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata,
  input logic [4:0]   m_axis_tuser,
  input logic         m_axis_tlast
);

  logic out_hs;
  assign out_hs = m_axis_tvalid && m_axis_tready;

  `STT_ASSERT_NEXT(a_stall_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

  `STT_ASSERT_SAME(a_error_sticky, m_axis_tvalid && m_axis_tuser[4], m_axis_tdata[127])

  `STT_ASSERT_SAME(a_error_kind, m_axis_tvalid,
    m_axis_tuser[4] == (m_axis_tuser[3:0] == TK_UNKNOWN))

  `STT_ASSERT_SAME(a_end_last, m_axis_tvalid && m_axis_tuser[3:0] == TK_END, m_axis_tlast)

  `STT_ASSERT_NEXT(a_quiet_after_end, out_hs && m_axis_tuser[3:0] == TK_END,
    !m_axis_tvalid)

endmodule

bind source_tokenizer_core sttok_checker u_sttok_checker (.*);

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for source_tokenizer_core
//
// source bytes go in on s_axis in random bursts while the token stream is
// throttled on a rotating stall pattern. a model of the scanner kept here
// works out the tokens each accepted byte should give, and every token
// transaction is checked field by field against the oldest one waiting.
// the run covers a short hand-written program, a long random program,
// tabs from every column of a tab stop, and the end of input with the
// bytes after it
// ----------------------------------------------------------------------------
module tb_top;
  import sttok_pkg::*;

  localparam int unsigned CLK_PERIOD   = 10;
  localparam int unsigned RESET_CYCLES = 5;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned RANDOM_BYTES = 1750;
  localparam int unsigned TIMEOUT_NS   = 2_000_000;

  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_VTAB     = 8'h0B;
  localparam logic [7:0] CH_FORMFEED = 8'h0C;
  localparam logic [7:0] CH_RETURN   = 8'h0D;
  localparam logic [7:0] CH_NUL      = 8'h00;

  typedef struct {
    tok_kind_e                kind;
    logic [POSITION_BITS-1:0] line;
    logic [POSITION_BITS-1:0] column;
    logic [26:0]              num;
    logic [63:0]              chars;
    logic [3:0]               len;
    logic                     err;
    logic                     sticky;
    logic                     last;
  } tok_exp_t;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata  = '0;
  logic         s_axis_tlast  = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic [4:0]   m_axis_tuser;
  logic         m_axis_tlast;

  // scanner state as seen by the bench
  scan_mode_e               scan_state = MODE_IDLE;
  logic [POSITION_BITS-1:0] line_pos   = POSITION_BITS'(1);
  logic [POSITION_BITS-1:0] col_pos    = POSITION_BITS'(1);
  logic [POSITION_BITS-1:0] tok_line   = POSITION_BITS'(1);
  logic [POSITION_BITS-1:0] tok_col    = POSITION_BITS'(1);
  logic [63:0]              word_buf   = '0;
  int unsigned              char_count = 0;
  logic [26:0]              num_acc    = '0;
  logic                     err_flag   = 1'b0;
  logic                     ended      = 1'b0;

  tok_exp_t    exp_tokens[$];
  tok_exp_t    step_tokens[$];
  tok_exp_t    want;
  int unsigned fail_count     = 0;
  int unsigned items_sent     = 0;
  int unsigned tokens_checked = 0;
  int unsigned burst_left     = 0;
  int unsigned kind_count [0:15];
  logic [11:0] stall_cnt;

  logic [POSITION_BITS-1:0] got_line, got_col;
  logic [26:0]              got_num;
  logic [63:0]              got_chars;
  logic [3:0]               got_len, got_kind;
  logic                     got_sticky, got_err;

  assign got_line   = m_axis_tdata[15:0];
  assign got_col    = m_axis_tdata[31:16];
  assign got_num    = m_axis_tdata[58:32];
  assign got_chars  = m_axis_tdata[122:59];
  assign got_len    = m_axis_tdata[126:123];
  assign got_sticky = m_axis_tdata[127];
  assign got_kind   = m_axis_tuser[3:0];
  assign got_err    = m_axis_tuser[4];

  source_tokenizer_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------- scanner

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDERSCORE;
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_NEWLINE || c == CH_VTAB ||
           c == CH_FORMFEED || c == CH_RETURN;
  endfunction

  function automatic tok_kind_e symbol_kind(input logic [7:0] c);
    case (c)
      CH_EQUALS: return TK_EQUALS;
      CH_PLUS:   return TK_PLUS;
      CH_MINUS:  return TK_MINUS;
      CH_STAR:   return TK_STAR;
      CH_SLASH:  return TK_SLASH;
      CH_SEMI:   return TK_SEMI;
      default:   return TK_UNKNOWN;
    endcase
  endfunction

  function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] v);
    return (v == POS_MAX) ? v : v + 1'b1;
  endfunction

  function automatic tok_exp_t make_tok(input tok_kind_e kind,
                                        input logic [POSITION_BITS-1:0] line,
                                        input logic [POSITION_BITS-1:0] column,
                                        input logic [26:0] num,
                                        input logic [63:0] chars,
                                        input logic [3:0] len,
                                        input logic err);
    tok_exp_t t;
    t.kind   = kind;
    t.line   = line;
    t.column = column;
    t.num    = num;
    t.chars  = chars;
    t.len    = len;
    t.err    = err;
    t.sticky = err_flag;
    t.last   = 1'b0;
    return t;
  endfunction

  // emit whatever identifier or number is still open
  task automatic flush_word();
    if (scan_state == MODE_IDENT) begin
      step_tokens.push_back(make_tok((char_count == 3 && word_buf == KW_INT_CHARS) ?
                                     TK_KW_INT : TK_IDENT, tok_line, tok_col, '0,
                                     word_buf, 4'(char_count), 1'b0));
    end else if (scan_state == MODE_NUMBER) begin
      step_tokens.push_back(make_tok(TK_NUMBER, tok_line, tok_col, num_acc, '0, '0, 1'b0));
    end
    scan_state = MODE_IDLE;
    word_buf   = '0;
    char_count = 0;
    num_acc    = '0;
  endtask

  task automatic predict_byte(input logic [7:0] c, input logic eoi);
    int unsigned nc;
    tok_kind_e   sym;
    step_tokens.delete();
    if (!ended) begin
      if (eoi || c == CH_NUL) begin
        flush_word();
        step_tokens.push_back(make_tok(TK_END, line_pos, col_pos, '0, '0, '0, 1'b0));
        ended = 1'b1;
      end else if (scan_state == MODE_IDENT && (is_letter(c) || is_digit(c))) begin
        if (char_count < IDENT_MAX_CHARS) begin
          word_buf[char_count*8 +: 8] = c;
          char_count++;
        end
        col_pos = sat_inc(col_pos);
      end else if (scan_state == MODE_NUMBER && is_digit(c)) begin
        if (char_count < IDENT_MAX_CHARS) begin
          num_acc = 27'(num_acc * 10) + 27'(c - "0");
          char_count++;
        end
        col_pos = sat_inc(col_pos);
      end else begin
        flush_word();
        if (is_letter(c)) begin
          scan_state = MODE_IDENT;
          tok_line   = line_pos;
          tok_col    = col_pos;
          word_buf   = 64'(c);
          char_count = 1;
          col_pos    = sat_inc(col_pos);
        end else if (is_digit(c)) begin
          scan_state = MODE_NUMBER;
          tok_line   = line_pos;
          tok_col    = col_pos;
          num_acc    = 27'(c - "0");
          char_count = 1;
          col_pos    = sat_inc(col_pos);
        end else if (c == CH_NEWLINE) begin
          col_pos  = POSITION_BITS'(1);
          line_pos = sat_inc(line_pos);
        end else if (c == CH_TAB) begin
          nc      = ((32'(col_pos) - 1) / TAB_STOP + 1) * TAB_STOP + 1;
          col_pos = (nc < POS_MAX_INT) ? POSITION_BITS'(nc) : POS_MAX;
        end else if (is_blank(c)) begin
          col_pos = sat_inc(col_pos);
        end else begin
          sym = symbol_kind(c);
          if (sym == TK_UNKNOWN) begin
            err_flag = 1'b1;
          end
          step_tokens.push_back(make_tok(sym, line_pos, col_pos, '0, '0, '0,
                                         sym == TK_UNKNOWN));
          col_pos = sat_inc(col_pos);
        end
      end
      if (step_tokens.size() != 0) begin
        step_tokens[step_tokens.size()-1].last = 1'b1;
      end
      foreach (step_tokens[i]) exp_tokens.push_back(step_tokens[i]);
    end
  endtask

  // ---------------------------------------------------------------- token side

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_cnt     <= '0;
    end else begin
      stall_cnt <= stall_cnt + 1'b1;
      case (stall_cnt[11:10])
        2'd0:    m_axis_tready <= 1'b1;
        2'd1:    m_axis_tready <= ($urandom_range(0, 3) != 0);
        2'd2:    m_axis_tready <= (stall_cnt[2:0] == 3'd0);
        default: m_axis_tready <= (stall_cnt[5:4] != 2'd3);
      endcase
    end
  end

  function automatic void compare_field(input string fname, input logic [63:0] want_v,
                                        input logic [63:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want_v, got_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (exp_tokens.size() == 0) begin
        $display("%0t: token transaction with none expected, expected none, actual kind %0d",
                 $time, got_kind);
        fail_count++;
      end else begin
        want = exp_tokens.pop_front();
        compare_field("token_kind", 64'(want.kind), 64'(got_kind));
        compare_field("token_line", 64'(want.line), 64'(got_line));
        compare_field("token_column", 64'(want.column), 64'(got_col));
        compare_field("number_value", 64'(want.num), 64'(got_num));
        compare_field("ident_chars", want.chars, got_chars);
        compare_field("ident_length", 64'(want.len), 64'(got_len));
        compare_field("token_error", 64'(want.err), 64'(got_err));
        compare_field("sticky_error", 64'(want.sticky), 64'(got_sticky));
        compare_field("last_of_run", 64'(want.last), 64'(m_axis_tlast));
      end
      tokens_checked++;
      kind_count[got_kind]++;
    end
  end

  // ---------------------------------------------------------------- byte side

  task automatic send_byte(input logic [7:0] b, input logic eoi);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eoi;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_byte(b, eoi);
    items_sent++;
    burst_left--;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  // hold the source back until every outstanding token has come out
  task automatic wait_for_tokens();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (exp_tokens.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [7:0] rand_letter();
    int unsigned r;
    r = $urandom_range(0, 52);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    return CH_UNDERSCORE;
  endfunction

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(0, 5))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_NEWLINE;
      3:       return CH_VTAB;
      4:       return CH_FORMFEED;
      default: return CH_RETURN;
    endcase
  endfunction

  function automatic logic [7:0] rand_symbol();
    case ($urandom_range(0, 5))
      0:       return CH_EQUALS;
      1:       return CH_PLUS;
      2:       return CH_MINUS;
      3:       return CH_STAR;
      4:       return CH_SLASH;
      default: return CH_SEMI;
    endcase
  endfunction

  function automatic logic [7:0] rand_stray_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255));
    while (is_letter(b) || is_digit(b) || is_blank(b) || symbol_kind(b) != TK_UNKNOWN);
    return b;
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_directed_tokens();
    send_text("int\v_Az09xyzQ=999999990;\n+-*/");
    send_byte(8'hFF, 1'b0);
    send_byte(CH_FORMFEED, 1'b0);
    send_byte(CH_RETURN, 1'b0);
    send_byte(CH_TAB, 1'b0);
    wait_for_tokens();
  endtask

  task automatic test_random_source();
    int unsigned start, len;
    start = items_sent;
    while (items_sent - start < RANDOM_BYTES) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: begin
          if ($urandom_range(0, 7) == 0) begin
            send_text("int");
          end else begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 8);
            send_byte(rand_letter(), 1'b0);
            repeat (len - 1) begin
              send_byte(($urandom_range(0, 3) == 0) ? 8'("0" + $urandom_range(0, 9)) :
                        rand_letter(), 1'b0);
            end
          end
        end
        6, 7, 8, 9: begin
          len = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 11) : $urandom_range(1, 8);
          if ($urandom_range(0, 5) == 0) begin
            repeat (len) send_byte("9", 1'b0);
          end else begin
            repeat (len) send_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
          end
        end
        10, 11, 12, 13: send_byte(rand_symbol(), 1'b0);
        14, 15, 16, 17: repeat ($urandom_range(1, 3)) send_byte(rand_blank(), 1'b0);
        18: send_byte(rand_stray_byte(), 1'b0);
        default: repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(1, 255)), 1'b0);
      endcase
    end
    wait_for_tokens();
  endtask

  // a tab from each column before, on and just past a tab stop
  task automatic test_tab_stops();
    for (int n = 0; n < 12; n++) begin
      send_byte(CH_NEWLINE, 1'b0);
      repeat (n) send_byte("a", 1'b0);
      send_byte(CH_TAB, 1'b0);
      send_byte(CH_SEMI, 1'b0);
      send_byte(CH_TAB, 1'b0);
      send_byte("7", 1'b0);
    end
    wait_for_tokens();
  endtask

  task automatic test_end_of_input();
    send_text("abc");
    send_byte("q", 1'b1);
    // everything after the end token is dropped
    send_byte(CH_NUL, 1'b0);
    send_byte(CH_PLUS, 1'b0);
    send_byte(8'hA5, 1'b1);
    send_text("z1");
    wait_for_tokens();
  endtask

  initial begin
    foreach (kind_count[i]) kind_count[i] = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_tokens();
    test_random_source();
    test_tab_stops();
    test_end_of_input();
    while (exp_tokens.size() != 0) @(posedge clk_i);
    repeat (4 * DRAIN_CYCLES) @(posedge clk_i);
    $display("sent %0d source bytes, checked %0d tokens", items_sent, tokens_checked);
    $display("ident %0d, int %0d, number %0d, end %0d, unknown %0d, other symbols %0d",
             kind_count[TK_IDENT], kind_count[TK_KW_INT], kind_count[TK_NUMBER],
             kind_count[TK_END], kind_count[TK_UNKNOWN],
             tokens_checked - kind_count[TK_IDENT] - kind_count[TK_KW_INT] -
             kind_count[TK_NUMBER] - kind_count[TK_END] - kind_count[TK_UNKNOWN]);
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb_top failed");
    $finish;
  end

endmodule
